// ===== rtl/gha_pkg.sv =====
// Shared constants, types and angle table of the heading and rotation core.
`default_nettype none

package gha_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int ANGLE_BITS        = 32;
  localparam int CORDIC_ITERATIONS = 16;

  localparam int GAIN_BITS  = 24;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd26702;

  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = SAMPLE_BITS + 1;
  localparam int SCALED_W   = SAMPLE_BITS + FRAC_BITS;  // input times 1/K, 16 fraction bits
  localparam int WORK_W     = SAMPLE_BITS + FRAC_BITS + 2;  // CORDIC x/y, room for sqrt(2) growth
  localparam int BAM_W      = 32;  // binary angle used by the rotator
  localparam int ITER_W     = $clog2(CORDIC_ITERATIONS);
  localparam int QUEUE_DEPTH = 2;

  // 1/K in Q30
  localparam logic signed [30:0] KINV_Q30 = 31'sd652032874;

  localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_BITS + 32 + 7) / 8) * 8;

  // One classified sample handed from the front to the rotator.
  typedef struct packed {
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic signed [BAM_W-1:0]  z;
    logic [ANGLE_BITS-1:0]    heading;
  } gha_job_t;

  // arctan(2^-i) in 2^-32 turn units
  function automatic logic [BAM_W-1:0] atan_bam(input logic [4:0] idx);
    logic [BAM_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gha_front.sv =====
// Front end: takes samples, integrates the heading, prescales and folds the angle.
`default_nettype none

module gha_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gha_pkg::GAIN_BITS-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gha_pkg::SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic [gha_pkg::SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic [gha_pkg::SAMPLE_BITS-1:0] in_yaw_rate,
  input  wire logic                          in_restart,
  output logic                               job_push,
  output gha_pkg::gha_job_t                  job_data,
  input  wire logic                          job_full
);
  import gha_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t                      state_r, state_nxt;
  logic [GAIN_BITS-1:0]         gain_r;
  logic [ANGLE_BITS-1:0]        heading_r, heading_nxt;

  logic signed [SAMPLE_BITS-1:0] ax_r, ay_r, rate_r;
  logic                          restart_r;
  logic [ANGLE_BITS-1:0]         delta_r;
  logic signed [SCALED_W-1:0]    xs_r, ys_r;

  logic signed [SAMPLE_BITS+GAIN_BITS:0] rate_full;
  logic signed [SAMPLE_BITS+30:0]        xprod, yprod;

  logic [ANGLE_BITS-1:0]        heading_base;
  logic [ANGLE_BITS-1:0]        neg_heading;
  logic [BAM_W-1:0]             p;
  logic                         fold;
  logic signed [WORK_W-1:0]     xw, yw;

  assign rate_full = rate_r * $signed({1'b0, gain_r});
  assign xprod     = ax_r * KINV_Q30;
  assign yprod     = ay_r * KINV_Q30;

  assign heading_base = restart_r ? '0 : heading_r;
  assign heading_nxt  = heading_base + delta_r;
  assign neg_heading  = '0 - heading_nxt;
  assign p            = BAM_W'(neg_heading) << (BAM_W - ANGLE_BITS);
  // second or third quadrant: negate the vector and take half a turn off
  assign fold         = p[BAM_W-1] ^ p[BAM_W-2];
  assign xw           = {{(WORK_W-SCALED_W){xs_r[SCALED_W-1]}}, xs_r};
  assign yw           = {{(WORK_W-SCALED_W){ys_r[SCALED_W-1]}}, ys_r};

  always_comb begin
    job_data.x       = fold ? -xw : xw;
    job_data.y       = fold ? -yw : yw;
    job_data.z       = $signed({p[BAM_W-1] ^ fold, p[BAM_W-2:0]});
    job_data.heading = heading_nxt;
  end

  assign in_ready = (state_r == F_IDLE);
  assign job_push = (state_r == F_PUSH) && !job_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (!job_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      gain_r    <= GAIN_RESET;
      heading_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) gain_r <= cfg_wdata;
      if (job_push) heading_r <= heading_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r      <= $signed(in_accel_x);
      ay_r      <= $signed(in_accel_y);
      rate_r    <= $signed(in_yaw_rate);
      restart_r <= in_restart;
    end
    if (state_r == F_MUL) begin
      delta_r <= rate_full[ANGLE_BITS-1:0];
      xs_r    <= xprod[SCALED_W+13:14];
      ys_r    <= yprod[SCALED_W+13:14];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gha_queue.sv =====
// Short job queue between the front end and the rotator.
`default_nettype none

module gha_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gha_pkg::gha_job_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output gha_pkg::gha_job_t      pop_data,
  output logic                   empty
);
  import gha_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  gha_job_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]      count_r;

  assign full     = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/gha_back.sv =====
// Rotator: iterative CORDIC on one job at a time, rounding and output register.
`default_nettype none

module gha_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         job_empty,
  input  wire gha_pkg::gha_job_t            job_data,
  output logic                              job_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gha_pkg::OUT_BITS-1:0]      out_rotated_x,
  output logic [gha_pkg::OUT_BITS-1:0]      out_rotated_y,
  output logic [31:0]                       out_heading
);
  import gha_pkg::*;

  localparam int RND_W = WORK_W - FRAC_BITS + 1;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERATIONS - 1);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} bstate_t;

  bstate_t                  state_r;
  logic signed [WORK_W-1:0] x_r, y_r;
  logic signed [BAM_W-1:0]  z_r;
  logic [ANGLE_BITS-1:0]    heading_r;
  logic [ITER_W-1:0]        iter_r;
  logic                     out_valid_r;
  logic [OUT_BITS-1:0]      rx_r, ry_r;
  logic [31:0]              hd_r;

  logic signed [WORK_W-1:0] dx, dy;
  logic signed [BAM_W-1:0]  da;
  logic                     out_load;
  logic [OUT_BITS-1:0]      rx_sat, ry_sat;

  function automatic logic [OUT_BITS-1:0] round_sat(input logic signed [WORK_W-1:0] v);
    logic [WORK_W:0]   sum;
    logic [RND_W-1:0]  rnd;
    logic [OUT_BITS-1:0] res;
    sum = {v[WORK_W-1], v} + (WORK_W+1)'(1 << (FRAC_BITS - 1));
    rnd = sum[WORK_W:FRAC_BITS];
    if (rnd[RND_W-1:OUT_BITS-1] == '0 || rnd[RND_W-1:OUT_BITS-1] == '1) begin
      res = rnd[OUT_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      res = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  assign dx = y_r >>> iter_r;
  assign dy = x_r >>> iter_r;
  assign da = $signed(atan_bam(5'(iter_r)));

  assign rx_sat = round_sat(x_r);
  assign ry_sat = round_sat(y_r);

  assign job_pop  = (state_r == B_IDLE) && !job_empty;
  assign out_load = (state_r == B_DONE) && (!out_valid_r || out_ready);

  assign out_valid     = out_valid_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_heading   = hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            state_r <= B_RUN;
            iter_r  <= '0;
          end
        end
        B_RUN: begin
          if (iter_r == LAST_ITER) state_r <= B_DONE;
          else                     iter_r  <= iter_r + 1'b1;
        end
        B_DONE: begin
          if (out_load) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
      if (out_load)                    out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (out_load) begin
        rx_r <= rx_sat;
        ry_r <= ry_sat;
        hd_r <= 32'(heading_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      x_r       <= job_data.x;
      y_r       <= job_data.y;
      z_r       <= job_data.z;
      heading_r <= job_data.heading;
    end else if (state_r == B_RUN) begin
      if (!z_r[BAM_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gyro_heading_accel_rotation_core.sv =====
// Top level of the heading-integrating acceleration rotation core.
//
// Input channel in_*: one IMU sample per item. in_tdata carries accel_x,
// accel_y and yaw_rate (signed, 16 bits each, lowest first); in_tuser[0] is
// the restart flag, which clears the heading before this sample is added.
// Output channel out_*: one result per sample, rotated_x and rotated_y (17-bit
// signed) and the updated heading (32-bit binary angle, full turn = 2^32).
// cfg_we/cfg_wdata load angle_gain, the heading step per rate count per
// sample; write it only while the core is idle.
//
// The item rate is set by the rotator, which works on one job at a time: a
// load state, one CORDIC step per cycle (16 steps), then a round/output state.
// The front end takes each item through capture, multiply, and integrate and
// fold, and hands jobs through a two-entry queue, so it runs ahead of the rotator.
// Reset (synchronous, rst_n low) clears the heading to zero, restores the
// default gain and empties the queue and output register. A stalled receiver
// holds the result in the output register; the rotator then waits, the queue
// fills and in_tready drops until space frees up.
`default_nettype none

module gyro_heading_accel_rotation_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gha_pkg::GAIN_BITS-1:0]   cfg_wdata,   // angle_gain
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [gha_pkg::IN_DATA_W-1:0]   in_tdata,    // accel_x, accel_y, yaw_rate
  input  wire logic [0:0]                      in_tuser,    // restart
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [gha_pkg::OUT_DATA_W-1:0]       out_tdata    // rotated_x, rotated_y, heading_out, zero pad
);
  import gha_pkg::*;

  gha_job_t             push_data, pop_data;
  logic                 push, pop, full, empty;
  logic [OUT_BITS-1:0]  rot_x, rot_y;
  logic [31:0]          heading_out;

  gha_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_accel_x  (in_tdata[SAMPLE_BITS-1:0]),
    .in_accel_y  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_yaw_rate (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .in_restart  (in_tuser[0]),
    .job_push    (push),
    .job_data    (push_data),
    .job_full    (full)
  );

  gha_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gha_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_empty     (empty),
    .job_data      (pop_data),
    .job_pop       (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_rotated_x (rot_x),
    .out_rotated_y (rot_y),
    .out_heading   (heading_out)
  );

  // Pack the result: rotated_x lowest, then rotated_y, heading, zero pad.
  assign out_tdata = OUT_DATA_W'({heading_out, rot_y, rot_x});

endmodule

`default_nettype wire

// ===== rtl/gha_checker.sv =====
// Port-level checker for the rotation core and its bind.
`default_nettype none

module gha_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [gha_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gha_pkg::*;

  // Hold a result until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // The front end works on one item at a time: ready drops after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after accept");

endmodule

bind gyro_heading_accel_rotation_core gha_checker u_gha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
